// ===== hw/rtl/ugnb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ugnb_pkg;

  // Default sizes
  localparam int GRID_DIM_MAX_DEF = 64;
  localparam int BIN_CAPACITY_DEF = 16;
  localparam int RESULT_LIMIT_DEF = 64;

  // Field widths
  localparam int ID_W   = 16;
  localparam int POS_W  = 32;
  localparam int INV_W  = 24;
  localparam int GDIM_W = 7;
  localparam int MAXF_W = 7;
  localparam int CELL_W = 8;   // covers a grid of up to 256 cells per side
  localparam int DIM_W  = 9;
  localparam int PROD_W = POS_W - 1 + INV_W;

  // Register indexes
  localparam logic [1:0] CFG_INV_CELL = 2'd0;
  localparam logic [1:0] CFG_GRID_DIM = 2'd1;
  localparam logic [1:0] CFG_MAX_FND  = 2'd2;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef struct packed {
    logic [1:0]        req;
    logic [ID_W-1:0]   id;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] found_id;
    logic            found_valid;
    logic            last;
    logic            status;
  } res_t;

  // Grid size in use: zero acts as one, large values saturate
  function automatic logic [DIM_W-1:0] eff_dim(input logic [GDIM_W-1:0] g,
                                               input logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] gx;
    gx = {{(DIM_W-GDIM_W){1'b0}}, g};
    if (g == '0) return DIM_W'(1);
    if (gx > mx) return mx;
    return gx;
  endfunction

  // Clamp a scaled coordinate to the grid; negative positions land in cell 0
  function automatic logic [CELL_W-1:0] to_cell(input logic neg,
                                                input logic [PROD_W-1:0] prod,
                                                input logic [DIM_W-1:0] dim);
    logic [PROD_W-33:0] c;
    c = prod[PROD_W-1:32];
    if (neg) return '0;
    if (c >= (PROD_W-32)'(dim)) return CELL_W'(dim - DIM_W'(1));
    return c[CELL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ugnb_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ugnb_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      rdata
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ugnb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ugnb_front #(
  parameter int GRID_DIM_MAX = ugnb_pkg::GRID_DIM_MAX_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [1:0]                in_req_type,
  input  wire logic [ugnb_pkg::ID_W-1:0]  in_item_id,
  input  wire logic [ugnb_pkg::POS_W-1:0] in_pos_x,
  input  wire logic [ugnb_pkg::POS_W-1:0] in_pos_y,
  input  wire logic [ugnb_pkg::INV_W-1:0] inv_scale,
  input  wire logic [ugnb_pkg::DIM_W-1:0] dim,
  output ugnb_pkg::cmd_t                  cmd,
  output logic                           cmd_push,
  input  wire logic                      cmd_full
);
  import ugnb_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MX   = 5'b00010,
    F_MY   = 5'b00100,
    F_CY   = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t             st_r, st_nxt;
  logic [1:0]          req_r;
  logic [ID_W-1:0]     id_r;
  logic [POS_W-1:0]    px_r, py_r;
  logic [PROD_W-1:0]   prod_r;
  logic [CELL_W-1:0]   cx_r, cy_r;
  logic [POS_W-2:0]    mul_a;

  assign in_full  = (st_r != F_IDLE);
  assign cmd_push = (st_r == F_PUSH);
  assign cmd      = '{req: req_r, id: id_r, cx: cx_r, cy: cy_r};
  assign mul_a    = (st_r == F_MX) ? px_r[POS_W-2:0] : py_r[POS_W-2:0];

  // Sequence: capture, scale x, scale y and clamp x, clamp y, hand off
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE:  if (in_push) st_nxt = F_MX;
      F_MX:    st_nxt = F_MY;
      F_MY:    st_nxt = F_CY;
      F_CY:    st_nxt = F_PUSH;
      F_PUSH:  if (!cmd_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= F_IDLE;
    else        st_r <= st_nxt;
  end

  // Capture the word, share one multiplier between both axes
  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_push) begin
      req_r <= in_req_type;
      id_r  <= in_item_id;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
    end
    if (st_r == F_MX || st_r == F_MY)
      prod_r <= PROD_W'(mul_a) * PROD_W'(inv_scale);
    if (st_r == F_MY) cx_r <= to_cell(px_r[POS_W-1], prod_r, dim);
    if (st_r == F_CY) cy_r <= to_cell(py_r[POS_W-1], prod_r, dim);
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_PUSH) |-> (32'(cx_r) < 32'(GRID_DIM_MAX)))
    else $error("x cell outside grid");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_PUSH) |-> (DIM_W'(cy_r) < dim))
    else $error("y cell outside grid in use");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_PUSH && cmd_full) |=> (st_r == F_PUSH) && $stable(cmd))
    else $error("command changed while held");
endmodule
`default_nettype wire

// ===== hw/rtl/ugnb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ugnb_back #(
  parameter int GRID_DIM_MAX = ugnb_pkg::GRID_DIM_MAX_DEF,
  parameter int BIN_CAPACITY = ugnb_pkg::BIN_CAPACITY_DEF,
  parameter int RESULT_LIMIT = ugnb_pkg::RESULT_LIMIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  ugnb_pkg::cmd_t                   cmd,
  input  wire logic                       cmd_empty,
  output logic                            cmd_pop,
  input  wire logic [ugnb_pkg::DIM_W-1:0]  dim,
  input  wire logic [ugnb_pkg::MAXF_W-1:0] max_found,
  output ugnb_pkg::res_t                   res,
  output logic                            res_push,
  input  wire logic                       res_full
);
  import ugnb_pkg::*;

  localparam int NUM_BINS = GRID_DIM_MAX * GRID_DIM_MAX;
  localparam int NUM_ENT  = NUM_BINS * BIN_CAPACITY;
  localparam int BIN_AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int ENT_AW   = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
  localparam int CNT_W    = $clog2(BIN_CAPACITY + 1);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_INS  = 7'b0000100,
    S_QCNT = 7'b0001000,
    S_QCHK = 7'b0010000,
    S_QENT = 7'b0100000,
    S_END  = 7'b1000000
  } bstate_t;

  bstate_t            st_r;
  logic [CNT_W-1:0]   cnt_mem [NUM_BINS];
  logic [ID_W-1:0]    ent_mem [NUM_ENT];
  logic [CNT_W-1:0]   cnt_q;
  logic [ID_W-1:0]    ent_q;
  logic               cnt_re, cnt_we, ent_re, ent_we;
  logic [BIN_AW-1:0]  cnt_raddr, cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [ENT_AW-1:0]  ent_raddr, ent_waddr;

  logic [BIN_AW-1:0]  clr_addr_r, bin_r;
  logic               clr_res_r, status_r, hold_v_r;
  logic [ID_W-1:0]    hold_id_r;
  logic [1:0]         dxi_r, dyi_r;
  logic [CNT_W-1:0]   k_r;
  logic [MAXF_W-1:0]  found_r, limit;
  logic [DIM_W-1:0]   cx9, cy9, nx, ny;
  logic [BIN_AW-1:0]  ins_bin, qry_bin;
  logic               clr_done, bin_full;

  // Query limit, saturated
  assign limit = (32'(max_found) > RESULT_LIMIT) ? MAXF_W'(RESULT_LIMIT) : max_found;

  // Neighbor cell with toroidal wrap
  assign cx9 = DIM_W'(cmd.cx);
  assign cy9 = DIM_W'(cmd.cy);
  always_comb begin
    case (dxi_r)
      2'd0:    nx = (cx9 == '0) ? dim - DIM_W'(1) : cx9 - DIM_W'(1);
      2'd1:    nx = cx9;
      default: nx = (cx9 + DIM_W'(1) == dim) ? '0 : cx9 + DIM_W'(1);
    endcase
    case (dyi_r)
      2'd0:    ny = (cy9 == '0) ? dim - DIM_W'(1) : cy9 - DIM_W'(1);
      2'd1:    ny = cy9;
      default: ny = (cy9 + DIM_W'(1) == dim) ? '0 : cy9 + DIM_W'(1);
    endcase
  end
  assign ins_bin = BIN_AW'(32'(cx9) + 32'(cy9) * 32'(dim));
  assign qry_bin = BIN_AW'(32'(nx) + 32'(ny) * 32'(dim));

  assign clr_done = (32'(clr_addr_r) == NUM_BINS - 1);
  assign bin_full = (cnt_q >= CNT_W'(BIN_CAPACITY));

  // Memory port controls
  always_comb begin
    cnt_re    = 1'b0;
    cnt_raddr = qry_bin;
    cnt_we    = 1'b0;
    cnt_waddr = bin_r;
    cnt_wdata = cnt_q + CNT_W'(1);
    ent_re    = (st_r == S_QCHK);
    ent_raddr = ENT_AW'(32'(bin_r) * BIN_CAPACITY + 32'(k_r));
    ent_we    = 1'b0;
    ent_waddr = ENT_AW'(32'(bin_r) * BIN_CAPACITY + 32'(cnt_q));
    if (st_r == S_IDLE && !cmd_empty && cmd.req == REQ_INSERT) begin
      cnt_re    = 1'b1;
      cnt_raddr = ins_bin;
    end
    if (st_r == S_QCNT) cnt_re = 1'b1;
    if (st_r == S_INS && !bin_full) begin
      cnt_we = 1'b1;
      ent_we = 1'b1;
    end
    if (st_r == S_CLR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr_r;
      cnt_wdata = '0;
    end
    ent_re = ent_re && (k_r < cnt_q) && (found_r < limit);
  end

  // Bin counts and entries, registered reads
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_q <= cnt_mem[cnt_raddr];
    if (ent_we) ent_mem[ent_waddr] <= cmd.id;
    if (ent_re) ent_q <= ent_mem[ent_raddr];
  end

  // Result word and command release
  assign res_push = ((st_r == S_END) || (st_r == S_QENT && hold_v_r)) && !res_full;
  assign res      = (st_r == S_END) ?
                    res_t'{found_id: hold_v_r ? hold_id_r : '0, found_valid: hold_v_r,
                           last: 1'b1, status: status_r} :
                    res_t'{found_id: hold_id_r, found_valid: 1'b1, last: 1'b0,
                           status: 1'b0};
  assign cmd_pop  = (st_r == S_END) && !res_full;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_CLR;
      clr_addr_r <= '0;
      clr_res_r  <= 1'b0;
      hold_v_r   <= 1'b0;
      status_r   <= 1'b0;
      found_r    <= '0;
    end else begin
      unique case (st_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + BIN_AW'(1);
          if (clr_done) begin
            clr_addr_r <= '0;
            st_r       <= clr_res_r ? S_END : S_IDLE;
          end
        end
        S_IDLE: begin
          hold_v_r  <= 1'b0;
          status_r  <= 1'b0;
          found_r   <= '0;
          dxi_r     <= 2'd0;
          dyi_r     <= 2'd0;
          bin_r     <= ins_bin;
          clr_res_r <= 1'b1;
          if (!cmd_empty) begin
            case (cmd.req)
              REQ_INSERT: st_r <= S_INS;
              REQ_QUERY:  st_r <= S_QCNT;
              REQ_CLEAR:  st_r <= S_CLR;
              default:    st_r <= S_END;
            endcase
          end
        end
        S_INS: begin
          status_r <= bin_full;
          st_r     <= S_END;
        end
        S_QCNT: begin
          bin_r <= qry_bin;
          k_r   <= '0;
          st_r  <= S_QCHK;
        end
        S_QCHK: begin
          if (k_r < cnt_q && found_r < limit) begin
            st_r <= S_QENT;
          end else if (dxi_r == 2'd2 && dyi_r == 2'd2) begin
            st_r <= S_END;
          end else begin
            if (dxi_r == 2'd2) begin
              dxi_r <= 2'd0;
              dyi_r <= dyi_r + 2'd1;
            end else begin
              dxi_r <= dxi_r + 2'd1;
            end
            st_r <= S_QCNT;
          end
        end
        S_QENT: begin
          if (!hold_v_r || !res_full) begin
            hold_id_r <= ent_q;
            hold_v_r  <= 1'b1;
            found_r   <= found_r + MAXF_W'(1);
            k_r       <= k_r + CNT_W'(1);
            st_r      <= S_QCHK;
          end
        end
        S_END: begin
          if (!res_full) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command released while none waits");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_QENT || st_r == S_QCHK) |-> (found_r <= limit))
    else $error("query exceeded its limit");
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res.last) |-> (st_r == S_QENT && res.found_valid))
    else $error("non-final result outside a query hit");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> (st_r == S_CLR || st_r == S_INS))
    else $error("count written outside insert or clear");
endmodule
`default_nettype wire

// ===== hw/rtl/uniform_grid_neighbor_bins.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port group   Handshake              Carries
// in_*         in_push / in_full      req_type, item_id, pos_x, pos_y
// out_*        out_pop / out_empty    found_id, found_valid, last, status
// cfg_*        cfg_we                 cfg_index, cfg_data (24 bits)
//
// Each request passes the front's capture, scale and clamp states (one shared
// multiplier scales x then y). Insert reads then writes its bin; a query walks the
// 3x3 neighbor bins; clear zeroes GRID_DIM_MAX*GRID_DIM_MAX bins, one bin per cycle.
// After reset the same pass clears all bin counts before the first request runs.
// A two-word queue between front and back and another on the results let each
// side stall on its own; reset is synchronous, active low.
module uniform_grid_neighbor_bins #(
  parameter int GRID_DIM_MAX = ugnb_pkg::GRID_DIM_MAX_DEF,
  parameter int BIN_CAPACITY = ugnb_pkg::BIN_CAPACITY_DEF,
  parameter int RESULT_LIMIT = ugnb_pkg::RESULT_LIMIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [1:0]                 in_req_type,
  input  wire logic [ugnb_pkg::ID_W-1:0]   in_item_id,
  input  wire logic [ugnb_pkg::POS_W-1:0]  in_pos_x,
  input  wire logic [ugnb_pkg::POS_W-1:0]  in_pos_y,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic [ugnb_pkg::ID_W-1:0]        out_found_id,
  output logic                            out_found_valid,
  output logic                            out_last,
  output logic                            out_status,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [ugnb_pkg::INV_W-1:0]  cfg_data
);
  import ugnb_pkg::*;

  logic [INV_W-1:0]  inv_cell_r;
  logic [GDIM_W-1:0] grid_dim_r;
  logic [MAXF_W-1:0] max_found_r;
  logic [DIM_W-1:0]  dim;
  cmd_t              cmd_in, cmd_out;
  logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
  res_t              res_in, res_out;
  logic              res_push, res_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_cell_r  <= INV_W'(65536);
      grid_dim_r  <= GDIM_W'(64);
      max_found_r <= MAXF_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_CELL: inv_cell_r  <= cfg_data;
        CFG_GRID_DIM: grid_dim_r  <= cfg_data[GDIM_W-1:0];
        CFG_MAX_FND:  max_found_r <= cfg_data[MAXF_W-1:0];
        default: ;
      endcase
    end
  end

  assign dim = eff_dim(grid_dim_r, DIM_W'(GRID_DIM_MAX));

  ugnb_front #(.GRID_DIM_MAX(GRID_DIM_MAX)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_item_id, .in_pos_x, .in_pos_y,
    .inv_scale(inv_cell_r), .dim, .cmd(cmd_in), .cmd_push, .cmd_full
  );

  ugnb_fifo #(.W($bits(cmd_t))) u_cmdq (
    .clk, .rst_n, .push(cmd_push), .wdata(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .empty(cmd_empty), .rdata(cmd_out)
  );

  ugnb_back #(
    .GRID_DIM_MAX(GRID_DIM_MAX), .BIN_CAPACITY(BIN_CAPACITY), .RESULT_LIMIT(RESULT_LIMIT)
  ) u_back (
    .clk, .rst_n, .cmd(cmd_out), .cmd_empty, .cmd_pop, .dim, .max_found(max_found_r),
    .res(res_in), .res_push, .res_full
  );

  ugnb_fifo #(.W($bits(res_t))) u_resq (
    .clk, .rst_n, .push(res_push), .wdata(res_in), .full(res_full),
    .pop(out_pop), .empty(out_empty), .rdata(res_out)
  );

  assign out_found_id    = res_out.found_id;
  assign out_found_valid = res_out.found_valid;
  assign out_last        = res_out.last;
  assign out_status      = res_out.status;
endmodule
`default_nettype wire
